// File: rtl/core/keyframe_curve_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Keyframe curve evaluator assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_CURVE_EVALUATOR_MACROS_SVH
`define KEYFRAME_CURVE_EVALUATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kce: implication check failed");

// next-cycle implication, disabled during reset
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kce: next-cycle check failed");

`endif

// File: rtl/core/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// Item types and operation / status codes of the keyframe curve evaluator.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int COUNT_W = 7;

    // operation codes
    localparam logic [1:0] OP_EVAL   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [2:0] ST_EVALUATED = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_UPDATED   = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_BAD_INDEX = 3'd6;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        key_time;
        logic signed [31:0] key_value;
        logic [2:0]         easing_kind;
        logic [5:0]         entry_index;
    } kce_in_t;

    typedef struct packed {
        logic signed [31:0]   result_value;
        logic [2:0]           status;
        logic [COUNT_W-1:0]   entry_count;
    } kce_out_t;

endpackage

// File: rtl/core/keyframe_curve_evaluator.sv
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator
// One sorted keyframe track in a single-port table memory: evaluate, add,
// remove and clear.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | kce_in_t
//   out     | output    | out_valid/ out_ready | kce_out_t
//   cfg     | input     | cfg_valid/ cfg_ready | match_window (16 bit)
//
// One item at a time. Search is binary; each probe reads the table and
// compares the returned entry. Evaluate: search, two table reads, divider,
// easing, multiply and saturate. Add/remove shift entries one at a time,
// with a read and a write per moved entry.
// Reset empties the table at once (count only, no memory pass).
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block stalls only when a second result is ready.
// ----------------------------------------------------------------------------
`include "keyframe_curve_evaluator_macros.svh"

module keyframe_curve_evaluator
    import kce_pkg::*;
#(
    parameter int MAX_KEYFRAMES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  kce_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output kce_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int CW = $clog2(MAX_KEYFRAMES + 1);

    typedef struct packed {
        logic [31:0]        ftime;
        logic signed [31:0] fvalue;
        logic [2:0]         feasing;
    } kce_entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_DISPATCH, S_EV_END, S_EV_LO, S_EV_UP, S_DIV,
        S_EASE_GO, S_EASE, S_MUL, S_FIN, S_ADD_CHK, S_SH_RD, S_SH_WR,
        S_RM_RD, S_RM_WR, S_DONE
    } state_t;

    // table memory
    kce_entry_t mem [MAX_KEYFRAMES];
    kce_entry_t rd_data_reg;
    logic       rd_en;
    logic [AW-1:0] rd_addr;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    kce_entry_t wr_data;

    state_t             state_reg;
    logic               srch_cmp_reg;
    logic [CW-1:0]      cnt_reg;
    logic [15:0]        win_reg;
    logic [1:0]         op_reg;
    logic [31:0]        t_reg;
    logic signed [31:0] v_reg;
    logic [2:0]         k_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      i_reg;
    logic [31:0]        t1_reg;
    logic signed [31:0] v1_reg;
    logic [2:0]         k1_reg;
    logic signed [32:0] delta_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        span_reg;
    logic [16:0]        q_reg;
    logic [4:0]         dcnt_reg;
    logic               ease_start_reg;
    logic signed [17:0] e_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] res_reg;
    logic [2:0]         status_reg;
    logic               out_valid_reg;
    kce_out_t           out_data_reg;

    logic [CW-1:0]      mid;
    logic               ease_done;
    logic signed [17:0] ease_val;
    logic [32:0]        rem_diff;
    logic [31:0]        span_new;
    logic [31:0]        num_new;
    logic signed [34:0] fin_sum;
    logic               add_match;

    assign mid       = CW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign rem_diff  = rem_reg - {1'b0, span_reg};
    assign span_new  = rd_data_reg.ftime - t1_reg;
    assign num_new   = ((t_reg - t1_reg) > span_new) ? span_new : t_reg - t1_reg;
    assign fin_sum   = 35'(v1_reg) + 35'(prod_reg >>> 16);
    assign add_match = (rd_data_reg.ftime - t_reg) < {16'd0, win_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        case (state_reg)
            S_SRCH:
            begin
                rd_en   = (lo_reg < hi_reg) && !srch_cmp_reg;
                rd_addr = mid[AW-1:0];
            end
            S_DISPATCH:
            begin
                if (op_reg == OP_EVAL && cnt_reg != '0)
                begin
                    rd_en = 1'b1;
                    if (lo_reg == '0)
                        rd_addr = '0;
                    else if (lo_reg >= cnt_reg)
                        rd_addr = AW'(cnt_reg - CW'(1));
                    else
                        rd_addr = AW'(lo_reg - CW'(1));
                end
                else if (op_reg == OP_ADD && lo_reg < cnt_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = lo_reg[AW-1:0];
                end
            end
            S_EV_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[AW-1:0];
            end
            S_ADD_CHK:
            begin
                wr_en   = add_match;
                wr_addr = lo_reg[AW-1:0];
                wr_data = '{ftime: rd_data_reg.ftime, fvalue: v_reg, feasing: k_reg};
            end
            S_SH_RD:
            begin
                if (i_reg > lo_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(i_reg - CW'(1));
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = lo_reg[AW-1:0];
                    wr_data = '{ftime: t_reg, fvalue: v_reg, feasing: k_reg};
                end
            end
            S_SH_WR, S_RM_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
            end
            S_RM_RD:
            begin
                rd_en   = (32'(i_reg) + 32'd1) < 32'(cnt_reg);
                rd_addr = AW'(i_reg + CW'(1));
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    kce_ease u_ease (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ease_start_reg),
        .kind  (k1_reg),
        .pos   (q_reg),
        .done  (ease_done),
        .ease  (ease_val)
    );

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            win_reg        <= 16'd65;
            out_valid_reg  <= 1'b0;
            ease_start_reg <= 1'b0;
            srch_cmp_reg   <= 1'b0;
        end
        else
        begin
            ease_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                win_reg <= cfg_data;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg  <= in_data.opcode;
                        t_reg   <= in_data.key_time;
                        v_reg   <= in_data.key_value;
                        k_reg   <= in_data.easing_kind;
                        res_reg <= 32'sd0;
                        lo_reg  <= '0;
                        hi_reg  <= cnt_reg;
                        case (in_data.opcode)
                            OP_REMOVE:
                            begin
                                if (32'(in_data.entry_index) >= 32'(cnt_reg))
                                begin
                                    status_reg <= ST_BAD_INDEX;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    i_reg     <= CW'(in_data.entry_index);
                                    state_reg <= S_RM_RD;
                                end
                            end
                            OP_CLEAR:
                            begin
                                cnt_reg    <= '0;
                                status_reg <= ST_CLEARED;
                                state_reg  <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_SRCH;
                            end
                        endcase
                    end
                end

                // binary search for the first entry at or after t
                S_SRCH:
                begin
                    if (lo_reg >= hi_reg)
                        state_reg <= S_DISPATCH;
                    else if (srch_cmp_reg)
                    begin
                        srch_cmp_reg <= 1'b0;
                        if (rd_data_reg.ftime < t_reg)
                            lo_reg <= CW'(mid + CW'(1));
                        else
                            hi_reg <= mid;
                    end
                    else
                        srch_cmp_reg <= 1'b1;
                end

                S_DISPATCH:
                begin
                    if (op_reg == OP_EVAL)
                    begin
                        status_reg <= ST_EVALUATED;
                        if (cnt_reg == '0)
                            state_reg <= S_DONE;
                        else if (lo_reg == '0 || lo_reg >= cnt_reg)
                            state_reg <= S_EV_END;
                        else
                            state_reg <= S_EV_LO;
                    end
                    else if (lo_reg < cnt_reg)
                        state_reg <= S_ADD_CHK;
                    else if (32'(cnt_reg) >= MAX_KEYFRAMES)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= cnt_reg;
                        state_reg <= S_SH_RD;
                    end
                end

                S_EV_END:
                begin
                    res_reg   <= rd_data_reg.fvalue;
                    state_reg <= S_DONE;
                end

                S_EV_LO:
                begin
                    t1_reg    <= rd_data_reg.ftime;
                    v1_reg    <= rd_data_reg.fvalue;
                    k1_reg    <= rd_data_reg.feasing;
                    state_reg <= S_EV_UP;
                end

                S_EV_UP:
                begin
                    if (rd_data_reg.ftime <= t1_reg)
                    begin
                        res_reg   <= v1_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        delta_reg <= 33'(rd_data_reg.fvalue) - 33'(v1_reg);
                        span_reg  <= span_new;
                        rem_reg   <= {1'b0, num_new};
                        q_reg     <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end

                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    if (rem_reg >= {1'b0, span_reg})
                    begin
                        q_reg   <= {q_reg[15:0], 1'b1};
                        rem_reg <= {rem_diff[31:0], 1'b0};
                    end
                    else
                    begin
                        q_reg   <= {q_reg[15:0], 1'b0};
                        rem_reg <= {rem_reg[31:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd16)
                        state_reg <= S_EASE_GO;
                end

                S_EASE_GO:
                begin
                    ease_start_reg <= 1'b1;
                    state_reg      <= S_EASE;
                end

                S_EASE:
                begin
                    if (ease_done)
                    begin
                        e_reg     <= ease_val;
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= delta_reg * e_reg;
                    state_reg <= S_FIN;
                end

                // saturate to 32 bits
                S_FIN:
                begin
                    if (fin_sum > 35'sd2147483647)
                        res_reg <= 32'sh7fffffff;
                    else if (fin_sum < -35'sd2147483648)
                        res_reg <= 32'sh80000000;
                    else
                        res_reg <= fin_sum[31:0];
                    state_reg <= S_DONE;
                end

                S_ADD_CHK:
                begin
                    if (add_match)
                    begin
                        status_reg <= ST_UPDATED;
                        state_reg  <= S_DONE;
                    end
                    else if (32'(cnt_reg) >= MAX_KEYFRAMES)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        i_reg     <= cnt_reg;
                        state_reg <= S_SH_RD;
                    end
                end

                // open a hole at the insert position
                S_SH_RD:
                begin
                    if (i_reg > lo_reg)
                        state_reg <= S_SH_WR;
                    else
                    begin
                        cnt_reg    <= CW'(cnt_reg + CW'(1));
                        status_reg <= ST_INSERTED;
                        state_reg  <= S_DONE;
                    end
                end

                S_SH_WR:
                begin
                    i_reg     <= CW'(i_reg - CW'(1));
                    state_reg <= S_SH_RD;
                end

                // close the gap left by the removed entry
                S_RM_RD:
                begin
                    if ((32'(i_reg) + 32'd1) < 32'(cnt_reg))
                        state_reg <= S_RM_WR;
                    else
                    begin
                        cnt_reg    <= CW'(cnt_reg - CW'(1));
                        status_reg <= ST_REMOVED;
                        state_reg  <= S_DONE;
                    end
                end

                S_RM_WR:
                begin
                    i_reg     <= CW'(i_reg + CW'(1));
                    state_reg <= S_RM_RD;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.result_value <= res_reg;
                        out_data_reg.status       <= status_reg;
                        out_data_reg.entry_count  <= COUNT_W'(cnt_reg);
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `KCE_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, 32'(cnt_reg) <= MAX_KEYFRAMES)
    `KCE_ASSERT_IMP(a_wr_in_table, clk, rst_n, wr_en, 32'(wr_addr) < MAX_KEYFRAMES)
    `KCE_ASSERT_IMP(a_ease_nonneg, clk, rst_n, ease_done, !ease_val[17])
    `KCE_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// File: rtl/core/kce_ease.sv
// ----------------------------------------------------------------------------
// kce_ease
// Easing curve unit: maps a Q.16 position to a signed Q2.16 factor with one
// shared multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
module kce_ease (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         kind,
    input  logic [16:0]        pos,
    output logic               done,
    output logic signed [17:0] ease
);

    localparam logic [2:0] EASE_IN      = 3'd1;
    localparam logic [2:0] EASE_OUT     = 3'd2;
    localparam logic [2:0] EASE_INOUT   = 3'd3;
    localparam logic [2:0] EASE_BOUNCE  = 3'd4;
    localparam logic [2:0] EASE_ELASTIC = 3'd5;

    typedef enum logic [3:0] {
        E_IDLE, E_SQ, E_MUL2, E_FIN, E_EL_PH, E_EL_G, E_EL_S, E_EL_GS, E_EL_FIN
    } ease_state_t;

    // 2^(-k/16) in Q16
    function automatic logic [16:0] pow2_lut(input logic [4:0] k);
        logic [16:0] r;
        begin
            case (k)
                5'd0:    r = 17'd65536;
                5'd1:    r = 17'd62757;
                5'd2:    r = 17'd60097;
                5'd3:    r = 17'd57549;
                5'd4:    r = 17'd55109;
                5'd5:    r = 17'd52773;
                5'd6:    r = 17'd50535;
                5'd7:    r = 17'd48393;
                5'd8:    r = 17'd46341;
                5'd9:    r = 17'd44376;
                5'd10:   r = 17'd42495;
                5'd11:   r = 17'd40693;
                5'd12:   r = 17'd38968;
                5'd13:   r = 17'd37316;
                5'd14:   r = 17'd35734;
                5'd15:   r = 17'd34219;
                default: r = 17'd32768;
            endcase
            return r;
        end
    endfunction

    // quarter sine wave, steps of 1/64 turn, Q16
    function automatic logic [16:0] sine_lut(input logic [4:0] k);
        logic [16:0] r;
        begin
            case (k)
                5'd0:    r = 17'd0;
                5'd1:    r = 17'd6424;
                5'd2:    r = 17'd12785;
                5'd3:    r = 17'd19024;
                5'd4:    r = 17'd25080;
                5'd5:    r = 17'd30893;
                5'd6:    r = 17'd36410;
                5'd7:    r = 17'd41576;
                5'd8:    r = 17'd46341;
                5'd9:    r = 17'd50660;
                5'd10:   r = 17'd54491;
                5'd11:   r = 17'd57798;
                5'd12:   r = 17'd60547;
                5'd13:   r = 17'd62714;
                5'd14:   r = 17'd64277;
                5'd15:   r = 17'd65220;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    ease_state_t        state_reg;
    logic [16:0]        p_reg;
    logic [2:0]         kind_reg;
    logic signed [54:0] prod_reg;
    logic signed [17:0] e_reg;
    logic               done_reg;
    logic [1:0]         quad_reg;
    logic [14:0]        r_reg;
    logic [16:0]        g_reg;

    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic [16:0]        sq_op;
    logic [16:0]        bdist;
    logic signed [18:0] b_off;
    logic [19:0]        x10;
    logic [15:0]        phase;
    logic [14:0]        r_mir;
    logic [16:0]        g_base;
    logic [4:0]         s_idx;
    logic signed [18:0] s_mag;
    logic signed [18:0] s_val;
    logic signed [18:0] ev;

    // operand of the squaring step and bounce segment
    always_comb
    begin
        bdist = 17'd0;
        b_off = 19'sd0;
        if (pos_lt(p_reg, 17'd23831))
        begin
            bdist = p_reg;
            b_off = 19'sd0;
        end
        else if (pos_lt(p_reg, 17'd47663))
        begin
            bdist = absdiff(p_reg, 17'd35747);
            b_off = 19'sd49152;
        end
        else if (pos_lt(p_reg, 17'd59578))
        begin
            bdist = absdiff(p_reg, 17'd53620);
            b_off = 19'sd61440;
        end
        else
        begin
            bdist = absdiff(p_reg, 17'd62557);
            b_off = 19'sd64512;
        end
        case (kind_reg)
            EASE_OUT:    sq_op = 17'd65536 - p_reg;
            EASE_INOUT:  sq_op = (p_reg < 17'd32768) ? p_reg
                                 : 17'(18'd131072 - {p_reg, 1'b0});
            EASE_BOUNCE: sq_op = bdist;
            default:     sq_op = p_reg;
        endcase
    end

    function automatic logic pos_lt(input logic [16:0] a, input logic [16:0] b);
        return a < b;
    endfunction

    function automatic logic [16:0] absdiff(input logic [16:0] a, input logic [16:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // elastic helpers
    assign x10    = {3'b000, p_reg} * 20'd10;
    assign phase  = prod_reg[36:21];
    assign r_mir  = phase[14] ? 15'(16'd16384 - {2'b00, phase[13:0]})
                              : {1'b0, phase[13:0]};
    assign g_base = pow2_lut({1'b0, x10[15:12]}) - 17'(prod_reg >>> 12);
    assign s_idx  = r_reg[14:10];
    assign s_mag  = (s_idx >= 5'd16) ? 19'sd65536
                    : 19'(sine_lut(s_idx)) + 19'(prod_reg >>> 10);
    assign s_val  = quad_reg[1] ? -s_mag : s_mag;

    // shared multiplier operands
    always_comb
    begin
        mul_a = 34'sd0;
        mul_b = 21'sd0;
        case (state_reg)
            E_SQ:
            begin
                mul_a = 34'(sq_op);
                mul_b = 21'(sq_op);
            end
            E_MUL2:
            begin
                mul_a = prod_reg[33:0];
                mul_b = 21'sd121;
            end
            E_EL_PH:
            begin
                mul_a = 34'sd699051;
                mul_b = 21'(x10 + 20'd147456);
            end
            E_EL_G:
            begin
                mul_a = 34'(pow2_lut({1'b0, x10[15:12]})
                            - pow2_lut(5'({1'b0, x10[15:12]} + 5'd1)));
                mul_b = 21'(x10[11:0]);
            end
            E_EL_S:
            begin
                if (s_idx < 5'd16)
                    mul_a = 34'(sine_lut(5'(s_idx + 5'd1)) - sine_lut(s_idx));
                mul_b = 21'(r_reg[9:0]);
            end
            E_EL_GS:
            begin
                mul_a = 34'(g_reg);
                mul_b = 21'(s_val);
            end
            default:
            begin
                mul_a = 34'sd0;
                mul_b = 21'sd0;
            end
        endcase
    end

    // final factor per curve
    always_comb
    begin
        case (kind_reg)
            EASE_IN:     ev = 19'(prod_reg >>> 16);
            EASE_OUT:    ev = 19'sd65536 - 19'(prod_reg >>> 16);
            EASE_INOUT:  ev = (p_reg < 17'd32768) ? 19'(prod_reg >>> 15)
                              : 19'sd65536 - 19'(prod_reg >>> 17);
            EASE_BOUNCE: ev = 19'(prod_reg >>> 20) + b_off;
            default:     ev = 19'(prod_reg >>> 16) + 19'sd65536;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            prod_reg <= mul_a * mul_b;
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        p_reg    <= pos;
                        kind_reg <= kind;
                        if (kind inside {EASE_IN, EASE_OUT, EASE_INOUT, EASE_BOUNCE})
                            state_reg <= E_SQ;
                        else if (kind == EASE_ELASTIC && pos != 17'd0 && !pos[16])
                            state_reg <= E_EL_PH;
                        else
                        begin
                            e_reg    <= 18'(pos);
                            done_reg <= 1'b1;
                        end
                    end
                end
                E_SQ:     state_reg <= (kind_reg == EASE_BOUNCE) ? E_MUL2 : E_FIN;
                E_MUL2:   state_reg <= E_FIN;
                E_EL_PH:  state_reg <= E_EL_G;
                E_EL_G:
                begin
                    quad_reg  <= phase[15:14];
                    r_reg     <= r_mir;
                    state_reg <= E_EL_S;
                end
                E_EL_S:
                begin
                    g_reg     <= g_base >> x10[19:16];
                    state_reg <= E_EL_GS;
                end
                E_EL_GS:  state_reg <= E_EL_FIN;
                E_FIN, E_EL_FIN:
                begin
                    e_reg     <= (ev > 19'sd131071) ? 18'sd131071 : ev[17:0];
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default:  state_reg <= E_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign ease = e_reg;

endmodule
